>>> hw/rtl/ppws_pkg.sv
// shared types and codes for the preemptive priority work scheduler
// request and result structs, action codes, chain command struct
// no dependencies
package ppws_pkg;

  localparam int ResBits   = 16;
  localparam int CountBits = 7;
  localparam int WeightBits = 40;

  localparam logic ACT_ARRIVE = 1'b0;
  localparam logic ACT_TICK   = 1'b1;

  typedef struct packed {
    logic        action;
    logic [15:0] work_units;
    logic [15:0] job_priority;
  } in_req_t;

  typedef struct packed {
    logic                  served_valid;
    logic [ResBits-1:0]    served_priority;
    logic [ResBits-1:0]    served_left;
    logic [CountBits-1:0]  job_count;
    logic [WeightBits-1:0] pending_weight;
    logic                  dropped;
  } out_res_t;

  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_INSERT,
    CMD_REMOVE
  } chain_cmd_e;

  typedef struct packed {
    chain_cmd_e cmd;
  } chain_ctl_t;

endpackage

>>> hw/rtl/ppws_cell.sv
// one slot of the sorted job chain, holding a {priority, work} key
// depends on ppws_pkg for the chain command struct
module ppws_cell #(
  parameter int KeyBits = 32
) (
  input  logic                 clk_i,
  input  ppws_pkg::chain_ctl_t ctl_i,
  input  logic [KeyBits-1:0]   new_key_i,
  input  logic                 valid_i,
  input  logic [KeyBits-1:0]   left_key_i,
  input  logic                 left_gt_i,
  input  logic [KeyBits-1:0]   right_key_i,
  output logic [KeyBits-1:0]   key_o,
  output logic                 gt_o
);
  import ppws_pkg::*;

  logic [KeyBits-1:0] key_q;
  logic [KeyBits-1:0] key_d;

  // an empty slot ranks below any job
  assign gt_o  = !valid_i || (new_key_i > key_q);
  assign key_o = key_q;

  always_comb begin
    key_d = key_q;
    unique case (ctl_i.cmd)
      CMD_INSERT: begin
        if (gt_o && !left_gt_i) begin
          key_d = new_key_i;
        end else if (gt_o) begin
          key_d = left_key_i;
        end
      end
      CMD_REMOVE: key_d = right_key_i;
      default:    key_d = key_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

endmodule

>>> hw/rtl/ppws_chain.sv
// row of ppws_cell slots kept sorted with the top job in slot 0
// depends on ppws_pkg and ppws_cell
module ppws_chain #(
  parameter int Depth     = 64,
  parameter int KeyBits   = 32,
  parameter int CountBits = 7
) (
  input  logic                 clk_i,
  input  ppws_pkg::chain_ctl_t ctl_i,
  input  logic [KeyBits-1:0]   new_key_i,
  input  logic [CountBits-1:0] count_i,
  output logic [KeyBits-1:0]   top_key_o
);
  import ppws_pkg::*;

  logic [KeyBits-1:0] key [Depth];
  logic [Depth-1:0]   gt;

  for (genvar i = 0; i < Depth; i++) begin : g_cell
    logic [KeyBits-1:0] left_key;
    logic               left_gt;
    logic [KeyBits-1:0] right_key;
    logic               slot_used;

    if (i == 0) begin : g_head
      assign left_key = new_key_i;
      assign left_gt  = 1'b0;
    end else begin : g_body
      assign left_key = key[i-1];
      assign left_gt  = gt[i-1];
    end

    if (i == Depth - 1) begin : g_tail
      assign right_key = key[i];
    end else begin : g_mid
      assign right_key = key[i+1];
    end

    assign slot_used = CountBits'(i) < count_i;

    ppws_cell #(
      .KeyBits(KeyBits)
    ) u_cell (
      .clk_i      (clk_i),
      .ctl_i      (ctl_i),
      .new_key_i  (new_key_i),
      .valid_i    (slot_used),
      .left_key_i (left_key),
      .left_gt_i  (left_gt),
      .right_key_i(right_key),
      .key_o      (key[i]),
      .gt_o       (gt[i])
    );
  end

  assign top_key_o = key[0];

endmodule

>>> hw/rtl/preemptive_priority_work_scheduler.sv
// preemptive priority work scheduler, top level
// depends on ppws_pkg and ppws_chain
//
// usage:
//   request channel in_valid_i / in_stall_o / in_req_i: action 0 queues a job
//   with its work and priority, action 1 serves the top job by one unit
//   result channel out_valid_o / out_stall_i / out_res_o: one result per request
// steps:
//   an arrival goes through the run and done states before the next request
//   slot, a tick that leaves work in its job through run, reinsert and done
//   (serve and unlink, then reinsert); the result is registered from done
//   each step is one parallel compare-and-shift over the whole cell chain, so
//   the steps do not depend on QUEUE_DEPTH
// reset:
//   queue empty, pending weight zero, no result pending
// stall:
//   a finished result waits in the output register; one further request is
//   taken and held until that register frees up
module preemptive_priority_work_scheduler #(
  parameter int QUEUE_DEPTH = 64,
  parameter int FIELD_BITS  = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  ppws_pkg::in_req_t  in_req_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output ppws_pkg::out_res_t out_res_o
);
  import ppws_pkg::*;

  localparam int KeyBits   = 2 * FIELD_BITS;
  localparam int CntBits   = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_REINS,
    S_DONE
  } state_e;

  state_e                state_q, state_d;
  logic                  act_q, act_d;
  logic [KeyBits-1:0]    key_q, key_d;
  logic [KeyBits-1:0]    prod_q, prod_d;
  logic [CntBits-1:0]    count_q, count_d;
  logic [WeightBits-1:0] weight_q, weight_d;
  logic                  srv_valid_q, srv_valid_d;
  logic [ResBits-1:0]    srv_prio_q, srv_prio_d;
  logic [ResBits-1:0]    srv_left_q, srv_left_d;
  logic                  drop_q, drop_d;
  logic                  out_valid_q;
  out_res_t              out_q;

  chain_ctl_t            ctl;
  logic [KeyBits-1:0]    top_key;
  logic [FIELD_BITS-1:0] in_work, in_prio;
  logic [FIELD_BITS-1:0] top_work, top_prio, top_left;
  logic [63:0]           prod_wide;
  logic                  full, out_free;

  assign in_work   = FIELD_BITS'(in_req_i.work_units);
  assign in_prio   = FIELD_BITS'(in_req_i.job_priority);
  assign top_work  = top_key[FIELD_BITS-1:0];
  assign top_prio  = top_key[KeyBits-1:FIELD_BITS];
  assign top_left  = (top_work == '0) ? '0 : top_work - 1'b1;
  assign prod_wide = 64'(prod_q);
  assign full      = count_q == CntBits'(QUEUE_DEPTH);
  assign out_free  = !out_valid_q || !out_stall_i;

  ppws_chain #(
    .Depth    (QUEUE_DEPTH),
    .KeyBits  (KeyBits),
    .CountBits(CntBits)
  ) u_chain (
    .clk_i    (clk_i),
    .ctl_i    (ctl),
    .new_key_i(key_q),
    .count_i  (count_q),
    .top_key_o(top_key)
  );

  always_comb begin
    state_d     = state_q;
    act_d       = act_q;
    key_d       = key_q;
    prod_d      = prod_q;
    count_d     = count_q;
    weight_d    = weight_q;
    srv_valid_d = srv_valid_q;
    srv_prio_d  = srv_prio_q;
    srv_left_d  = srv_left_q;
    drop_d      = drop_q;
    ctl.cmd     = CMD_NONE;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          act_d       = in_req_i.action;
          key_d       = {in_prio, in_work};
          prod_d      = KeyBits'(in_work) * KeyBits'(in_prio);
          srv_valid_d = 1'b0;
          srv_prio_d  = '0;
          srv_left_d  = '0;
          drop_d      = 1'b0;
          state_d     = S_RUN;
        end
      end
      S_RUN: begin
        state_d = S_DONE;
        if (act_q == ACT_ARRIVE) begin
          if (full) begin
            drop_d = 1'b1;
          end else begin
            ctl.cmd  = CMD_INSERT;
            count_d  = count_q + 1'b1;
            weight_d = weight_q + prod_wide[WeightBits-1:0];
          end
        end else if (count_q != '0) begin
          srv_valid_d = 1'b1;
          srv_prio_d  = ResBits'(top_prio);
          srv_left_d  = ResBits'(top_left);
          if (top_work != '0) begin
            weight_d = weight_q - WeightBits'(top_prio);
          end
          // unlink the top job; it goes back in on the next cycle if work remains
          ctl.cmd = CMD_REMOVE;
          count_d = count_q - 1'b1;
          key_d   = {top_prio, top_left};
          if (top_left != '0) begin
            state_d = S_REINS;
          end
        end
      end
      S_REINS: begin
        ctl.cmd = CMD_INSERT;
        count_d = count_q + 1'b1;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      act_q       <= ACT_ARRIVE;
      key_q       <= '0;
      prod_q      <= '0;
      count_q     <= '0;
      weight_q    <= '0;
      srv_valid_q <= 1'b0;
      srv_prio_q  <= '0;
      srv_left_q  <= '0;
      drop_q      <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q     <= state_d;
      act_q       <= act_d;
      key_q       <= key_d;
      prod_q      <= prod_d;
      count_q     <= count_d;
      weight_q    <= weight_d;
      srv_valid_q <= srv_valid_d;
      srv_prio_q  <= srv_prio_d;
      srv_left_q  <= srv_left_d;
      drop_q      <= drop_d;
      if (state_q == S_DONE && out_free) begin
        out_valid_q           <= 1'b1;
        out_q.served_valid    <= srv_valid_q;
        out_q.served_priority <= srv_prio_q;
        out_q.served_left     <= srv_left_q;
        out_q.job_count       <= CountBits'(count_q);
        out_q.pending_weight  <= weight_q;
        out_q.dropped         <= drop_q;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign in_stall_o  = state_q != S_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

endmodule

>>> hw/rtl/ppws_checker.sv
// port-level checks for the preemptive priority work scheduler
// depends on ppws_pkg; bound to the top level at the end of this file
module ppws_checker #(
  parameter int QUEUE_DEPTH = 64
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input ppws_pkg::out_res_t out_res_o
);
  import ppws_pkg::*;

  localparam logic [CountBits-1:0] FullCount = CountBits'(QUEUE_DEPTH);

  // one request at a time: busy right after taking one
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request taken while previous one still in work");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_res_o))
    else $error("stalled result changed or vanished");

  // a refused arrival only happens with the queue full
  a_drop_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_res_o.dropped |-> out_res_o.job_count == FullCount)
    else $error("arrival dropped with room in queue");

  a_drop_no_serve: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_res_o.dropped |-> !out_res_o.served_valid)
    else $error("result both served and dropped");

  a_idle_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_res_o.served_valid |->
      out_res_o.served_priority == '0 && out_res_o.served_left == '0)
    else $error("served fields set with no job served");

endmodule

bind preemptive_priority_work_scheduler ppws_checker #(
  .QUEUE_DEPTH(QUEUE_DEPTH)
) u_ppws_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_res_o  (out_res_o)
);

>>> bench/tb_preemptive_priority_work_scheduler.sv
// self-checking testbench for preemptive_priority_work_scheduler
// keeps its own model of the job queue and compares every result in order
// depends on ppws_pkg and the scheduler rtl
`timescale 1ns / 100ps

module tb_preemptive_priority_work_scheduler;
  import ppws_pkg::*;

  localparam int QUEUE_DEPTH    = 64;
  localparam int FIELD_BITS     = 16;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int TAIL_CYCLES    = 20;

  logic     clk_i;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_stall_o;
  in_req_t  in_req_i;
  logic     out_valid_o;
  logic     out_stall_i;
  out_res_t out_res_o;

  // scheduler model state
  logic [15:0] job_work_q [QUEUE_DEPTH];
  logic [15:0] job_prio_q [QUEUE_DEPTH];
  int unsigned job_cnt = 0;
  logic [39:0] weight_sum = '0;

  out_res_t expected_results[$];
  int unsigned mismatch_count = 0;
  int unsigned stuck_cycles = 0;
  bit idle_en = 1'b1;
  bit hold_req = 1'b0;

  preemptive_priority_work_scheduler #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .FIELD_BITS (FIELD_BITS)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_res_o  (out_res_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // higher priority wins, then more remaining work
  function automatic bit ranks_above(int unsigned a, int unsigned b);
    if (job_prio_q[a] != job_prio_q[b]) return job_prio_q[a] > job_prio_q[b];
    return job_work_q[a] > job_work_q[b];
  endfunction

  function automatic out_res_t schedule_step(in_req_t r);
    out_res_t res;
    int unsigned top;
    logic [39:0] w40;
    logic [39:0] p40;
    res = '0;
    if (r.action == ACT_ARRIVE) begin
      if (job_cnt >= QUEUE_DEPTH) begin
        res.dropped = 1'b1;
      end else begin
        job_work_q[job_cnt] = r.work_units;
        job_prio_q[job_cnt] = r.job_priority;
        job_cnt++;
        w40 = {24'd0, r.work_units};
        p40 = {24'd0, r.job_priority};
        weight_sum = weight_sum + w40 * p40;
      end
    end else if (job_cnt > 0) begin
      top = 0;
      for (int unsigned i = 1; i < job_cnt; i++) begin
        if (ranks_above(i, top)) top = i;
      end
      res.served_valid = 1'b1;
      res.served_priority = job_prio_q[top];
      if (job_work_q[top] != 0) begin
        job_work_q[top] = job_work_q[top] - 16'd1;
        weight_sum = weight_sum - {24'd0, job_prio_q[top]};
      end
      res.served_left = job_work_q[top];
      // retired job is replaced by the last queued one
      if (job_work_q[top] == 0) begin
        job_cnt--;
        job_work_q[top] = job_work_q[job_cnt];
        job_prio_q[top] = job_prio_q[job_cnt];
      end
    end
    res.job_count = 7'(job_cnt);
    res.pending_weight = weight_sum;
    return res;
  endfunction

  function automatic in_req_t arrival(logic [15:0] work, logic [15:0] prio);
    in_req_t r;
    r.action = ACT_ARRIVE;
    r.work_units = work;
    r.job_priority = prio;
    return r;
  endfunction

  // tick fields are don't-care, so they carry random bits
  function automatic in_req_t random_tick();
    in_req_t r;
    r.action = ACT_TICK;
    r.work_units = 16'($urandom);
    r.job_priority = 16'($urandom);
    return r;
  endfunction

  // mostly short jobs on a few priority levels so ties and retirements are common
  function automatic in_req_t random_arrival();
    int unsigned sel;
    logic [15:0] work;
    logic [15:0] prio;
    sel = $urandom_range(0, 31);
    if (sel == 0) work = 16'($urandom);
    else if (sel < 8) work = 16'($urandom_range(0, 40));
    else work = 16'($urandom_range(0, 3));
    prio = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3));
    return arrival(work, prio);
  endfunction

  function automatic in_req_t random_item(int unsigned arrive_pct);
    if ($urandom_range(0, 99) < arrive_pct) return random_arrival();
    return random_tick();
  endfunction

  task automatic send_req(input in_req_t r);
    if (idle_en && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i <= r;
    do @(posedge clk_i); while (in_stall_o);
    expected_results.push_back(schedule_step(r));
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (expected_results.size() != 0);
  endtask

  task automatic check_field(input string field, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      if (mismatch_count < 10)
        $display("mismatch on %s: expected %0h, actual %0h", field, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk_i) begin : check_results
    out_res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        if (mismatch_count < 10) $display("unexpected result: %p", out_res_o);
        mismatch_count++;
      end else begin
        want = expected_results.pop_front();
        check_field("served_valid", 64'(want.served_valid),
                    64'(out_res_o.served_valid));
        check_field("served_priority", 64'(want.served_priority),
                    64'(out_res_o.served_priority));
        check_field("served_left", 64'(want.served_left),
                    64'(out_res_o.served_left));
        check_field("job_count", 64'(want.job_count),
                    64'(out_res_o.job_count));
        check_field("pending_weight", 64'(want.pending_weight),
                    64'(out_res_o.pending_weight));
        check_field("dropped", 64'(want.dropped),
                    64'(out_res_o.dropped));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) stuck_cycles <= 0;
    else stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_preemptive_priority_work_scheduler failed");
      $finish;
    end
  end

  // result side: random stall bursts, plus one long hold-off on request
  initial begin
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        out_stall_i <= 1'b0;
        hold_req = 1'b0;
      end else if (idle_en && $urandom_range(0, 7) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic test_directed();
    send_req(random_tick());                 // nothing queued yet
    send_req(arrival(16'h0000, 16'hFFFF));   // zero-work job
    send_req(arrival(16'd5, 16'd7));
    send_req(arrival(16'd9, 16'd7));         // same priority, more work
    send_req(arrival(16'hFFFF, 16'h0000));
    send_req(arrival(16'd1, 16'hFFFF));
    send_req(random_tick());
    send_req(random_tick());                 // zero-work job retires
    repeat (5) send_req(random_tick());
    send_req(arrival(16'hFFFF, 16'hFFFF));
    send_req(arrival(16'h0001, 16'h0001));
    send_req(random_tick());
    send_req(random_tick());
    send_req(arrival(16'h5555, 16'hAAAA));
    send_req(arrival(16'hAAAA, 16'h5555));
    send_req(random_tick());
  endtask

  task automatic test_fill_and_drop();
    while (job_cnt < QUEUE_DEPTH) send_req(random_arrival());
    repeat (4) send_req(arrival(16'($urandom), 16'($urandom)));
    repeat (150) send_req(random_tick());
  endtask

  task automatic test_random_mix();
    int unsigned pct;
    for (int phase = 0; phase < 10; phase++) begin
      case ($urandom_range(0, 2))
        0: pct = 20;
        1: pct = 50;
        default: pct = 85;
      endcase
      repeat (110) send_req(random_item(pct));
    end
  endtask

  // results are held back long enough for the request side to back up
  task automatic test_backpressure();
    hold_req = 1'b1;
    repeat (24) send_req(random_item(60));
    wait_drained();
  endtask

  task automatic test_no_idle();
    idle_en = 1'b0;
    repeat (300) send_req(random_item(50));
  endtask

  initial begin
    rst_ni <= 1'b0;
    in_valid_i <= 1'b0;
    in_req_i <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_fill_and_drop();
    test_random_mix();
    test_backpressure();
    test_no_idle();
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("tb_preemptive_priority_work_scheduler passed");
    end else begin
      $display("tb_preemptive_priority_work_scheduler failed");
    end
    $finish;
  end

endmodule
